// ===== rtl/rtd_pkg.sv =====
// rtd_pkg: shared types, codes and the symbol lookup of the radix text decoder
// used by every rtl file of the decoder; depends on nothing else
package rtd_pkg;

   // decode modes (mode three decodes as crockford)
   localparam logic [1:0] MODE_BASE64    = 2'd0;
   localparam logic [1:0] MODE_BASE32    = 2'd1;
   localparam logic [1:0] MODE_CROCKFORD = 2'd2;

   // status codes on a final result
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   localparam logic [7:0] CHAR_PAD = 8'h3D;

   // queue sizes, both powers of two so that pointers wrap by themselves
   localparam int FRONT_DEPTH  = 2;
   localparam int FRONT_PTR_W  = $clog2(FRONT_DEPTH);
   localparam int FRONT_CNT_W  = $clog2(FRONT_DEPTH + 1);
   localparam int RESULT_DEPTH = 4;
   localparam int RESULT_PTR_W = $clog2(RESULT_DEPTH);
   localparam int RESULT_CNT_W = $clog2(RESULT_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_PAD    = 2'd1,
      KIND_SYMBOL = 2'd2,
      KIND_BAD    = 2'd3
   } kind_type;

   // classified input item
   typedef struct packed {
      kind_type    kind;
      logic [5:0]  value;
      logic        last;
   } item_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [3:0]  valid_bits;
      logic        is_final;
      logic [1:0]  status;
   } result_type;

   // up to two results written in one cycle, first is the older
   typedef struct packed {
      logic [1:0]  count;
      result_type  first;
      result_type  second;
   } result_push_type;

   // returns {hit, value} of one character in the given mode
   function automatic logic [6:0] symbol_lookup(input logic [7:0] c, input logic [1:0] mode);
      logic       hit;
      logic [7:0] v;
      hit = 1'b0;
      v   = 8'd0;
      if (mode == MODE_BASE64) begin
         if (c >= "A" && c <= "Z") begin
            hit = 1'b1; v = c - "A";
         end else if (c >= "a" && c <= "z") begin
            hit = 1'b1; v = c - "a" + 8'd26;
         end else if (c >= "0" && c <= "9") begin
            hit = 1'b1; v = c - "0" + 8'd52;
         end else if (c == "+") begin
            hit = 1'b1; v = 8'd62;
         end else if (c == "/") begin
            hit = 1'b1; v = 8'd63;
         end
      end else if (mode == MODE_BASE32) begin
         if (c >= "A" && c <= "Z") begin
            hit = 1'b1; v = c - "A";
         end else if (c >= "2" && c <= "7") begin
            hit = 1'b1; v = c - "2" + 8'd26;
         end
      end else begin
         if (c >= "0" && c <= "9") begin
            hit = 1'b1; v = c - "0";
         end else if (c >= "A" && c <= "H") begin
            hit = 1'b1; v = c - "A" + 8'd10;
         end else if (c >= "J" && c <= "K") begin
            hit = 1'b1; v = c - "J" + 8'd18;
         end else if (c >= "M" && c <= "N") begin
            hit = 1'b1; v = c - "M" + 8'd20;
         end else if (c >= "P" && c <= "T") begin
            hit = 1'b1; v = c - "P" + 8'd22;
         end else if (c >= "V" && c <= "Z") begin
            hit = 1'b1; v = c - "V" + 8'd27;
         end
      end
      return {hit, v[5:0]};
   endfunction

endpackage

// ===== rtl/rtd_front.sv =====
// rtd_front: accepts input transactions, classifies each character and
// queues the classified items for the back end; depends on rtd_pkg
module rtd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          mode,
   input  logic                req_push,
   input  logic                req_has_char,
   input  logic [7:0]          req_symbol_char,
   input  logic                req_end_of_input,
   output logic                req_full,
   output logic                item_valid,
   output rtd_pkg::item_type   item,
   input  logic                item_take
);

   rtd_pkg::item_type                 queue_ff [rtd_pkg::FRONT_DEPTH];
   logic [rtd_pkg::FRONT_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [rtd_pkg::FRONT_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [rtd_pkg::FRONT_CNT_W-1:0]   count_ff, count_in;
   logic [6:0]                        lookup;
   rtd_pkg::item_type                 new_item;
   logic                              accept;
   logic                              write;

   // classify the incoming character
   always_comb begin
      lookup         = rtd_pkg::symbol_lookup(req_symbol_char, mode);
      new_item.value = lookup[5:0];
      new_item.last  = req_end_of_input;
      priority if (!req_has_char) begin
         new_item.kind = rtd_pkg::KIND_NONE;
      end else if (req_symbol_char == rtd_pkg::CHAR_PAD) begin
         new_item.kind = rtd_pkg::KIND_PAD;
      end else if (lookup[6]) begin
         new_item.kind = rtd_pkg::KIND_SYMBOL;
      end else begin
         new_item.kind = rtd_pkg::KIND_BAD;
      end
   end

   // a bare item without character and end has no effect and is dropped here
   assign req_full = (count_ff == rtd_pkg::FRONT_CNT_W'(rtd_pkg::FRONT_DEPTH));
   assign accept   = req_push && !req_full;
   assign write    = accept && (req_has_char || req_end_of_input);

   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = write ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = item_take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + rtd_pkg::FRONT_CNT_W'(write)
                           - rtd_pkg::FRONT_CNT_W'(item_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (write) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== rtl/rtd_back.sv =====
// rtd_back: carries out classified items, packs symbol bits into bytes and
// checks the text at its end; depends on rtd_pkg
module rtd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [1:0]                mode,
   input  logic                      item_valid,
   input  rtd_pkg::item_type         item,
   output logic                      item_take,
   input  logic                      space_ok,
   output rtd_pkg::result_push_type  push
);

   logic [6:0]  residual_bits_ff, residual_bits_in;
   logic [2:0]  residual_count_ff, residual_count_in;
   logic [2:0]  symbol_count_ff, symbol_count_in;
   logic        any_symbol_ff, any_symbol_in;
   logic [2:0]  pad_count_ff, pad_count_in;
   logic        pad_seen_ff, pad_seen_in;
   logic [5:0]  last_value_ff, last_value_in;
   logic        error_seen_ff, error_seen_in;

   logic [3:0]  sym_bits;
   logic [12:0] acc;
   logic [3:0]  cnt;
   logic        byte_ready;
   logic [3:0]  cnt_left;
   logic [12:0] keep_mask;
   logic [7:0]  byte_value;
   logic [1:0]  end_status;
   rtd_pkg::result_type byte_result;
   rtd_pkg::result_type end_result;

   // rules checked on the whole text at its end
   function automatic logic [1:0] final_status(
      input logic [1:0] md,
      input logic [2:0] syms,
      input logic [2:0] pads,
      input logic       any,
      input logic       padded,
      input logic       err,
      input logic [5:0] last,
      input logic [2:0] rc
   );
      logic [3:0] sum;
      logic [7:0] tail_mask;
      logic [7:0] pad_mask;
      sum       = {1'b0, syms} + {1'b0, pads};
      tail_mask = (8'd1 << rc) - 8'd1;
      pad_mask  = (pads == 3'd1) ? 8'd3 : 8'd15;
      if (!any && !padded && !err) return rtd_pkg::STATUS_EMPTY;
      if (err) return rtd_pkg::STATUS_INVALID;
      if (md == rtd_pkg::MODE_BASE64 || md == rtd_pkg::MODE_BASE32) begin
         if (md == rtd_pkg::MODE_BASE64) begin
            if (sum[1:0] != 2'd0) return rtd_pkg::STATUS_INVALID;
            if (pads > 3'd2) return rtd_pkg::STATUS_INVALID;
            if (pads == 3'd1 && syms[1:0] != 2'd3) return rtd_pkg::STATUS_INVALID;
            if (pads == 3'd2 && syms[1:0] != 2'd2) return rtd_pkg::STATUS_INVALID;
            if (pads != 3'd0 && (pad_mask & {2'b00, last}) != 8'd0)
               return rtd_pkg::STATUS_INVALID;
         end else begin
            if (sum[2:0] != 3'd0) return rtd_pkg::STATUS_INVALID;
            if (pads > 3'd6) return rtd_pkg::STATUS_INVALID;
            if (pads != 3'd0 &&
                !((pads == 3'd6 && syms == 3'd2) || (pads == 3'd4 && syms == 3'd4) ||
                  (pads == 3'd3 && syms == 3'd5) || (pads == 3'd1 && syms == 3'd7)))
               return rtd_pkg::STATUS_INVALID;
         end
         if (rc != 3'd0 && (tail_mask & {2'b00, last}) != 8'd0)
            return rtd_pkg::STATUS_INVALID;
         if (syms == 3'd0 && !any) return rtd_pkg::STATUS_EMPTY;
         if (any && syms == 3'd0) return rtd_pkg::STATUS_OK;
         if (syms <= 3'd1) return rtd_pkg::STATUS_EMPTY;
         return rtd_pkg::STATUS_OK;
      end
      if (pads != 3'd0) return rtd_pkg::STATUS_INVALID;
      if (!any) return rtd_pkg::STATUS_EMPTY;
      return rtd_pkg::STATUS_OK;
   endfunction

   // take an item only when both of its results fit
   assign item_take = item_valid && space_ok;

   // bit packing of one symbol
   always_comb begin
      sym_bits   = (mode == rtd_pkg::MODE_BASE64) ? 4'd6 : 4'd5;
      acc        = (13'(residual_bits_ff) << sym_bits) | 13'(item.value);
      cnt        = {1'b0, residual_count_ff} + sym_bits;
      byte_ready = (cnt >= 4'd8);
      cnt_left   = byte_ready ? cnt - 4'd8 : cnt;
      keep_mask  = (13'd1 << cnt_left) - 13'd1;
      byte_value = 8'(acc >> cnt_left);
      byte_result.data_byte  = byte_value;
      byte_result.valid_bits = 4'd8;
      byte_result.is_final   = 1'b0;
      byte_result.status     = rtd_pkg::STATUS_OK;
   end

   // state update and result generation
   always_comb begin
      residual_bits_in  = residual_bits_ff;
      residual_count_in = residual_count_ff;
      symbol_count_in   = symbol_count_ff;
      any_symbol_in     = any_symbol_ff;
      pad_count_in      = pad_count_ff;
      pad_seen_in       = pad_seen_ff;
      last_value_in     = last_value_ff;
      error_seen_in     = error_seen_ff;
      push              = '0;
      end_status        = rtd_pkg::STATUS_OK;
      end_result        = '0;

      if (item_take && !error_seen_ff) begin
         unique case (item.kind)
            rtd_pkg::KIND_PAD: begin
               pad_seen_in = 1'b1;
               if (pad_count_ff != 3'd7) begin
                  pad_count_in = pad_count_ff + 3'd1;
               end
            end
            rtd_pkg::KIND_SYMBOL: begin
               if (pad_seen_ff) begin
                  error_seen_in = 1'b1;
               end else begin
                  last_value_in     = item.value;
                  symbol_count_in   = symbol_count_ff + 3'd1;
                  any_symbol_in     = 1'b1;
                  residual_count_in = cnt_left[2:0];
                  residual_bits_in  = 7'(acc & keep_mask);
                  if (byte_ready) begin
                     push.count = 2'd1;
                     push.first = byte_result;
                  end
               end
            end
            rtd_pkg::KIND_BAD: begin
               error_seen_in = 1'b1;
            end
            rtd_pkg::KIND_NONE: begin
            end
         endcase
      end

      // end of text: status, crockford tail bits, then a fresh state
      if (item_take && item.last) begin
         end_status = final_status(mode, symbol_count_in, pad_count_in, any_symbol_in,
                                   pad_seen_in, error_seen_in, last_value_in,
                                   residual_count_in);
         end_result.is_final = 1'b1;
         end_result.status   = end_status;
         if (mode[1] && end_status == rtd_pkg::STATUS_OK && residual_count_in != 3'd0) begin
            end_result.data_byte  = 8'({1'b0, residual_bits_in} <<
                                       (4'd8 - {1'b0, residual_count_in}));
            end_result.valid_bits = {1'b0, residual_count_in};
         end
         if (push.count == 2'd0) begin
            push.first = end_result;
         end else begin
            push.second = end_result;
         end
         push.count = push.count + 2'd1;

         residual_bits_in  = '0;
         residual_count_in = '0;
         symbol_count_in   = '0;
         any_symbol_in     = 1'b0;
         pad_count_in      = '0;
         pad_seen_in       = 1'b0;
         last_value_in     = '0;
         error_seen_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         residual_bits_ff  <= '0;
         residual_count_ff <= '0;
         symbol_count_ff   <= '0;
         any_symbol_ff     <= 1'b0;
         pad_count_ff      <= '0;
         pad_seen_ff       <= 1'b0;
         last_value_ff     <= '0;
         error_seen_ff     <= 1'b0;
      end else begin
         residual_bits_ff  <= residual_bits_in;
         residual_count_ff <= residual_count_in;
         symbol_count_ff   <= symbol_count_in;
         any_symbol_ff     <= any_symbol_in;
         pad_count_ff      <= pad_count_in;
         pad_seen_ff       <= pad_seen_in;
         last_value_ff     <= last_value_in;
         error_seen_ff     <= error_seen_in;
      end
   end

endmodule

// ===== rtl/rtd_result_fifo.sv =====
// rtd_result_fifo: result queue that takes up to two results a cycle and
// hands out one per pop transaction; depends on rtd_pkg
module rtd_result_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  rtd_pkg::result_push_type  push,
   output logic                      space_ok,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output rtd_pkg::result_type       head
);

   rtd_pkg::result_type               entry_ff [rtd_pkg::RESULT_DEPTH];
   logic [rtd_pkg::RESULT_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [rtd_pkg::RESULT_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [rtd_pkg::RESULT_CNT_W-1:0]  count_ff, count_in;
   logic [rtd_pkg::RESULT_PTR_W-1:0]  wr_next;
   logic                              pop;

   assign rsp_empty = (count_ff == '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign pop       = rsp_pop && !rsp_empty;
   // room for the worst case of two results
   assign space_ok  = (count_ff <= rtd_pkg::RESULT_CNT_W'(rtd_pkg::RESULT_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + 1'b1;

   // pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + rtd_pkg::RESULT_PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + rtd_pkg::RESULT_CNT_W'(push.count)
                           - rtd_pkg::RESULT_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

// ===== rtl/radix_text_decoder.sv =====
// radix_text_decoder: top level of the base64 / base32 / crockford decoder
// depends on rtd_pkg, rtd_front, rtd_back and rtd_result_fifo
//
// Usage
//   Input queue: drive req_has_char, req_symbol_char and req_end_of_input and
//   raise req_push; the transaction is taken at an edge where req_full is low.
//   Every decoded byte comes out as soon as it forms; the item marked end of
//   input yields one final result with status, plus tail bits in crockford mode.
//   Result queue: while rsp_empty is low the oldest result is on rsp_*; a pop
//   transaction takes it. Bytes of a text whose final status is not ok are junk.
//   csr_decode_mode is written with csr_valid (csr_ready is always high). The
//   user must write it only while no text is in flight; the block does not enforce it.
// Throughput and stalls
//   A taken input transaction waits in the item queue, then the back end decodes it
//   into the result queue. One input transaction per cycle is taken while req_full
//   is low; an item may give two results and the result queue drains one per cycle
//   of pops, so that port sets the long-run rate. The back end stalls when the result queue lacks room for two.
// Reset
//   Both queues empty, decode state cleared, mode base64. A stalled result
//   side fills the result queue, then the item queue, then raises req_full.
module radix_text_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_has_char,
   input  logic [7:0]  req_symbol_char,
   input  logic        req_end_of_input,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_data_byte,
   output logic [3:0]  rsp_valid_bits,
   output logic        rsp_is_final,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_decode_mode
);

   logic [1:0]                mode_ff;
   logic                      item_valid;
   logic                      item_take;
   rtd_pkg::item_type         item;
   logic                      space_ok;
   rtd_pkg::result_push_type  push;
   rtd_pkg::result_type       head;

   // mode register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= rtd_pkg::MODE_BASE64;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_decode_mode;
      end
   end

   rtd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .mode             (mode_ff),
      .req_push         (req_push),
      .req_has_char     (req_has_char),
      .req_symbol_char  (req_symbol_char),
      .req_end_of_input (req_end_of_input),
      .req_full         (req_full),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take)
   );

   rtd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .space_ok   (space_ok),
      .push       (push)
   );

   rtd_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .head      (head)
   );

   // result fields
   assign rsp_data_byte  = head.data_byte;
   assign rsp_valid_bits = head.valid_bits;
   assign rsp_is_final   = head.is_final;
   assign rsp_status     = head.status;

endmodule

// ===== rtl/rtd_checker.sv =====
// rtd_checker: port level checks of the radix text decoder, bound to the top
// depends on the top level's ports and on rtd_pkg for the status codes
module rtd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [7:0]  rsp_data_byte,
   input logic [3:0]  rsp_valid_bits,
   input logic        rsp_is_final,
   input logic [1:0]  rsp_status
);

   // nothing waits right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("result or input queue not empty after reset");

   // a byte result is always a whole byte with a clean status
   a_byte_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_is_final)
         |-> (rsp_valid_bits == 4'd8 && rsp_status == rtd_pkg::STATUS_OK))
      else $error("non-final result is not a whole byte");

   // tail bits only on an ok final result, and never a whole byte
   a_tail_bits: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_final && rsp_valid_bits != 4'd0)
         |-> (rsp_status == rtd_pkg::STATUS_OK && rsp_valid_bits < 4'd8))
      else $error("final result carries data it should not");

   // a waiting result holds until it is popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data_byte)
         && $stable(rsp_valid_bits) && $stable(rsp_is_final) && $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind radix_text_decoder rtd_checker u_rtd_checker (.*);

// ===== dv/radix_text_decoder_checker.sv =====
// radix_text_decoder_checker: watches the decoder's request, response and csr
// channels, predicts every result and compares it; needs rtd_pkg only
`timescale 1ns / 100ps
module radix_text_decoder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic        req_has_char,
   input  logic [7:0]  req_symbol_char,
   input  logic        req_end_of_input,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [7:0]  rsp_data_byte,
   input  logic [3:0]  rsp_valid_bits,
   input  logic        rsp_is_final,
   input  logic [1:0]  rsp_status,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_decode_mode,
   output int          mismatches,
   output int          outstanding
);
   import rtd_pkg::*;

   // decoder state as the predictor sees it
   logic [1:0] mode_reg;
   logic [6:0] tail_bits;
   logic [2:0] tail_count;
   logic [2:0] symbol_phase;
   bit         saw_symbol;
   logic [2:0] pad_total;
   bit         saw_pad;
   logic [5:0] last_value;
   bit         broken;

   result_type decoded_results[$];

   task automatic clear_text();
      tail_bits    = '0;
      tail_count   = '0;
      symbol_phase = '0;
      saw_symbol   = 1'b0;
      pad_total    = '0;
      saw_pad      = 1'b0;
      last_value   = '0;
      broken       = 1'b0;
   endtask

   // symbol value of one character, -1 when the alphabet has no such symbol
   function automatic int symbol_value(input logic [7:0] c, input logic [1:0] mode);
      int v;
      if (mode == MODE_BASE64) begin
         if (c >= "A" && c <= "Z") return c - "A";
         if (c >= "a" && c <= "z") return c - "a" + 26;
         if (c >= "0" && c <= "9") return c - "0" + 52;
         if (c == "+") return 62;
         if (c == "/") return 63;
         return -1;
      end
      if (mode == MODE_BASE32) begin
         if (c >= "A" && c <= "Z") return c - "A";
         if (c >= "2" && c <= "7") return c - "2" + 26;
         return -1;
      end
      // crockford: digits, then letters with I, L, O and U skipped
      if (c >= "0" && c <= "9") return c - "0";
      if (c < "A" || c > "Z" || c == "I" || c == "L" || c == "O" || c == "U") return -1;
      v = c - "A" + 10;
      if (c > "I") v--;
      if (c > "L") v--;
      if (c > "O") v--;
      if (c > "U") v--;
      return v;
   endfunction

   // verdict of the end item on the text seen so far
   function automatic logic [1:0] text_status();
      int unsigned syms;
      int unsigned pads;
      int unsigned grp;
      syms = symbol_phase;
      pads = pad_total;
      if (!saw_symbol && !saw_pad && !broken) return STATUS_EMPTY;
      if (broken) return STATUS_INVALID;
      if (mode_reg >= MODE_CROCKFORD) begin
         if (pads != 0) return STATUS_INVALID;
         return saw_symbol ? STATUS_OK : STATUS_EMPTY;
      end
      grp = (mode_reg == MODE_BASE64) ? 4 : 8;
      if ((syms + pads) % grp != 0) return STATUS_INVALID;
      if (pads == 0 && syms % grp != 0) return STATUS_INVALID;
      if (mode_reg == MODE_BASE64) begin
         if (pads > 2) return STATUS_INVALID;
         if (pads == 1 && syms % 4 != 3) return STATUS_INVALID;
         if (pads == 2 && syms % 4 != 2) return STATUS_INVALID;
         if (pads != 0 && (last_value & (pads == 1 ? 3 : 15)) != 0) return STATUS_INVALID;
      end else begin
         if (pads > 6) return STATUS_INVALID;
         if (pads != 0 && !((pads == 6 && syms == 2) || (pads == 4 && syms == 4) ||
                            (pads == 3 && syms == 5) || (pads == 1 && syms == 7)))
            return STATUS_INVALID;
      end
      // leftover bits of the last symbol must be zero
      if (tail_count != 0 && (last_value & ((1 << tail_count) - 1)) != 0)
         return STATUS_INVALID;
      if (!saw_symbol) return STATUS_EMPTY;
      if (syms == 0) return STATUS_OK;
      if (syms <= 1) return STATUS_EMPTY;
      return STATUS_OK;
   endfunction

   // one accepted request: queue the bytes and the final result it causes
   task automatic decode_step(input logic has, input logic [7:0] c, input logic last);
      int          v;
      int unsigned width;
      int unsigned acc;
      int unsigned cnt;
      result_type  r;
      logic [1:0]  st;
      if (has && !broken) begin
         if (c == CHAR_PAD) begin
            saw_pad = 1'b1;
            if (pad_total != 3'd7) pad_total++;
         end else begin
            v = symbol_value(c, mode_reg);
            if (saw_pad || v < 0) begin
               broken = 1'b1;
            end else begin
               width = (mode_reg == MODE_BASE64) ? 6 : 5;
               acc   = (32'(tail_bits) << width) | v;
               cnt   = tail_count + width;
               last_value = v[5:0];
               symbol_phase++;
               saw_symbol = 1'b1;
               if (cnt >= 8) begin
                  cnt          -= 8;
                  r.data_byte  = 8'(acc >> cnt);
                  r.valid_bits = 4'd8;
                  r.is_final   = 1'b0;
                  r.status     = STATUS_OK;
                  decoded_results.push_back(r);
               end
               tail_count = cnt[2:0];
               tail_bits  = 7'(acc & ((1 << cnt) - 1));
            end
         end
      end
      if (last) begin
         st           = text_status();
         r.data_byte  = '0;
         r.valid_bits = '0;
         // crockford hands out the leftover bits, left aligned
         if (mode_reg >= MODE_CROCKFORD && st == STATUS_OK && tail_count != 0) begin
            r.data_byte  = 8'(32'(tail_bits) << (8 - tail_count));
            r.valid_bits = 4'(tail_count);
         end
         r.is_final = 1'b1;
         r.status   = st;
         decoded_results.push_back(r);
         clear_text();
      end
   endtask

   task automatic note_mismatch(input string what, input bit has_want,
                                input result_type want, input result_type got);
      if (mismatches < 10) begin
         if (has_want)
            $display("%0t %s: expected byte %h bits %0d final %b status %0d, got byte %h bits %0d final %b status %0d",
                     $realtime, what, want.data_byte, want.valid_bits, want.is_final,
                     want.status, got.data_byte, got.valid_bits, got.is_final, got.status);
         else
            $display("%0t %s: got byte %h bits %0d final %b status %0d", $realtime, what,
                     got.data_byte, got.valid_bits, got.is_final, got.status);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         mode_reg = MODE_BASE64;
         clear_text();
         decoded_results.delete();
      end else begin
         // response transaction against the oldest prediction
         if (rsp_pop && !rsp_empty) begin
            got.data_byte  = rsp_data_byte;
            got.valid_bits = rsp_valid_bits;
            got.is_final   = rsp_is_final;
            got.status     = rsp_status;
            if (decoded_results.size() == 0) begin
               note_mismatch("unexpected result", 1'b0, got, got);
            end else begin
               want = decoded_results.pop_front();
               if (got.data_byte !== want.data_byte || got.valid_bits !== want.valid_bits ||
                   got.is_final !== want.is_final || got.status !== want.status)
                  note_mismatch("result mismatch", 1'b1, want, got);
            end
         end
         // csr transaction
         if (csr_valid && csr_ready) mode_reg = csr_decode_mode;
         // request transaction
         if (req_push && !req_full) decode_step(req_has_char, req_symbol_char, req_end_of_input);
      end
      outstanding = decoded_results.size();
   end

endmodule

// ===== dv/radix_text_decoder_tb.sv =====
// radix_text_decoder_tb: stimulus and verdict for the radix text decoder
// needs rtd_pkg, the decoder rtl and radix_text_decoder_checker
`timescale 1ns / 100ps
module radix_text_decoder_tb;
   import rtd_pkg::*;

   localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, decodes as crockford
   localparam int RANDOM_ITEMS = 1300;
   localparam int IDLE_SETTLE  = 10;
   localparam int HOLD_CYCLES  = 300;

   typedef enum int {
      DAMAGE_CHAR,
      DAMAGE_DROP_LAST,
      DAMAGE_EXTRA_PAD,
      DAMAGE_TRAILING_SYMBOL,
      DAMAGE_LAST_SYMBOL,
      DAMAGE_INSERT,
      DAMAGE_GARBAGE
   } damage_kind;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_push         = 1'b0;
   logic       req_has_char     = 1'b0;
   logic [7:0] req_symbol_char  = '0;
   logic       req_end_of_input = 1'b0;
   logic       rsp_pop          = 1'b0;
   logic       csr_valid        = 1'b0;
   logic [1:0] csr_decode_mode  = MODE_BASE64;
   logic       req_full;
   logic       rsp_empty;
   logic [7:0] rsp_data_byte;
   logic [3:0] rsp_valid_bits;
   logic       rsp_is_final;
   logic [1:0] rsp_status;
   logic       csr_ready;
   int         mismatches;
   int         outstanding;

   logic [1:0] cur_mode = MODE_BASE64;
   logic [7:0] text_q[$];
   int         items_sent  = 0;
   int         tx_style    = 0;
   int         tx_left     = 0;
   int         rx_style    = 0;
   int         rx_left     = 0;
   int         hold_ask    = 0;
   int         hold_served = 0;

   always #5 clock = ~clock;

   radix_text_decoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_has_char     (req_has_char),
      .req_symbol_char  (req_symbol_char),
      .req_end_of_input (req_end_of_input),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_valid_bits   (rsp_valid_bits),
      .rsp_is_final     (rsp_is_final),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_decode_mode  (csr_decode_mode)
   );

   radix_text_decoder_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_has_char     (req_has_char),
      .req_symbol_char  (req_symbol_char),
      .req_end_of_input (req_end_of_input),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_valid_bits   (rsp_valid_bits),
      .rsp_is_final     (rsp_is_final),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_decode_mode  (csr_decode_mode),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   // character for a symbol value in the given mode
   function automatic logic [7:0] enc_symbol(input logic [1:0] mode, input int v);
      logic [7:0] ch;
      if (mode == MODE_BASE64) begin
         if (v < 26) return 8'("A" + v);
         if (v < 52) return 8'("a" + v - 26);
         if (v < 62) return 8'("0" + v - 52);
         return (v == 62) ? 8'("+") : 8'("/");
      end
      if (mode == MODE_BASE32) return (v < 26) ? 8'("A" + v) : 8'("2" + v - 26);
      if (v < 10) return 8'("0" + v);
      ch = 8'("A" + v - 10);
      if (ch >= "I") ch++;
      if (ch >= "L") ch++;
      if (ch >= "O") ch++;
      if (ch >= "U") ch++;
      return ch;
   endfunction

   // one request transaction after a drawn gap
   task automatic send_item(input bit has, input logic [7:0] ch, input bit last);
      int gap;
      if (tx_left == 0) begin
         tx_style = $urandom_range(0, 2);
         tx_left  = $urandom_range(10, 60);
      end
      tx_left--;
      gap = (tx_style == 0) ? 0 : (tx_style == 1) ? $urandom_range(0, 12) : $urandom_range(0, 2);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_has_char     <= has;
      req_symbol_char  <= ch;
      req_end_of_input <= last;
      do @(posedge clock); while (req_full);
      if (has || last) items_sent++;
   endtask

   task automatic send_text(input string s, input bit bare_end, input bit close);
      for (int i = 0; i < s.len(); i++)
         send_item(1'b1, s[i], close && !bare_end && i == s.len() - 1);
      if (close && bare_end) send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
   endtask

   // stop offering and let every expected result drain out
   task automatic wait_idle();
      req_push <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic set_mode(input logic [1:0] m);
      wait_idle();
      csr_valid       <= 1'b1;
      csr_decode_mode <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_mode = m;
   endtask

   // one text: mostly a proper encoding, sometimes damaged, then sent
   task automatic send_random_text();
      int          nbytes;
      int          width;
      int          grp;
      int          cnt;
      int          pos;
      int unsigned acc;
      bit          bare_end;
      damage_kind  k;
      string       rejects;
      rejects = "ILOi";
      text_q.delete();
      nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      width  = (cur_mode == MODE_BASE64) ? 6 : 5;
      if (cur_mode >= MODE_CROCKFORD) begin
         repeat (nbytes + $urandom_range(0, 2))
            text_q.push_back(enc_symbol(cur_mode, $urandom_range(0, 31)));
      end else begin
         grp = (cur_mode == MODE_BASE64) ? 4 : 8;
         acc = 0;
         cnt = 0;
         repeat (nbytes) begin
            acc = ((acc << 8) | $urandom_range(0, 255)) & 32'hFFFF;
            cnt += 8;
            while (cnt >= width) begin
               cnt -= width;
               text_q.push_back(enc_symbol(cur_mode, (acc >> cnt) & ((1 << width) - 1)));
            end
         end
         if (cnt > 0)
            text_q.push_back(enc_symbol(cur_mode, (acc << (width - cnt)) & ((1 << width) - 1)));
         while (text_q.size() % grp != 0) text_q.push_back(CHAR_PAD);
      end
      // damage about one text in four
      if ($urandom_range(0, 3) == 0) begin
         k = damage_kind'($urandom_range(0, 6));
         case (k)
            DAMAGE_CHAR: begin
               if (text_q.size() > 0)
                  text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
            DAMAGE_DROP_LAST: begin
               if (text_q.size() > 0) void'(text_q.pop_back());
            end
            DAMAGE_EXTRA_PAD: text_q.push_back(CHAR_PAD);
            DAMAGE_TRAILING_SYMBOL: begin
               text_q.push_back(enc_symbol(cur_mode, $urandom_range(0, 31)));
            end
            DAMAGE_LAST_SYMBOL: begin
               pos = text_q.size() - 1;
               while (pos >= 0 && text_q[pos] == CHAR_PAD) pos--;
               if (pos >= 0)
                  text_q[pos] = enc_symbol(cur_mode, $urandom_range(0, (1 << width) - 1));
            end
            DAMAGE_INSERT: begin
               pos = $urandom_range(0, text_q.size());
               if (cur_mode >= MODE_CROCKFORD)
                  text_q.insert(pos, rejects[$urandom_range(0, 3)]);
               else
                  text_q.insert(pos, CHAR_PAD);
            end
            default: begin
               text_q.delete();
               repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
            end
         endcase
      end
      bare_end = (text_q.size() == 0) || ($urandom_range(0, 4) == 0);
      foreach (text_q[i]) begin
         // now and then a bare item that the decoder ignores
         if ($urandom_range(0, 19) == 0) send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
         send_item(1'b1, text_q[i], !bare_end && i == text_q.size() - 1);
      end
      if (bare_end) send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
   endtask

   // response side: random pop stalls, one long hold when asked
   initial begin
      int stall;
      wait (reset == 1'b0);
      forever begin
         if (hold_served != hold_ask) begin
            hold_served = hold_ask;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (rx_left == 0) begin
               rx_style = $urandom_range(0, 2);
               rx_left  = $urandom_range(10, 60);
            end
            rx_left--;
            stall = (rx_style == 0) ? 0 :
                    (rx_style == 1) ? $urandom_range(0, 12) : $urandom_range(0, 2);
            if (stall > 0) begin
               rsp_pop <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   // run limit
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // stimulus and verdict
   initial begin
      int  next_switch;
      bit  pressure_done;
      pressure_done = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed texts, base64 first (reset mode)
      send_item(1'b0, 8'h00, 1'b1);                  // empty text
      send_text("/w==", 1'b0, 1'b1);                 // all-ones byte, two pads
      send_item(1'b1, "Q", 1'b0);                    // symbol after pad, then noise
      send_item(1'b1, CHAR_PAD, 1'b0);
      send_item(1'b1, "Q", 1'b0);
      send_item(1'b1, 8'hFF, 1'b1);
      set_mode(MODE_BASE32);
      send_text("MY======", 1'b0, 1'b1);             // six pads
      set_mode(MODE_CROCKFORD);
      send_item(1'b0, 8'h5A, 1'b0);                  // bare item, ignored
      send_text("ZZZ0", 1'b1, 1'b1);                 // tail bits, bare end marker
      send_text("I", 1'b0, 1'b1);                    // rejected letter
      send_text("0=", 1'b0, 1'b1);                   // pad in crockford
      set_mode(MODE_SPARE);
      send_text("V", 1'b0, 1'b1);
      // mode change in the middle of a text
      set_mode(MODE_BASE64);
      send_text("Q", 1'b0, 1'b0);
      set_mode(MODE_CROCKFORD);
      send_text("Z", 1'b0, 1'b1);

      // random texts with mode changes between phases
      items_sent  = 0;
      next_switch = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= next_switch) begin
            set_mode(2'($urandom_range(0, 3)));
            next_switch = items_sent + $urandom_range(100, 250);
         end
         // long response hold while requests keep coming back to back
         if (!pressure_done && items_sent >= 400) begin
            pressure_done = 1'b1;
            hold_ask++;
            tx_style = 0;
            tx_left  = 80;
         end
         send_random_text();
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rtd_pkg.sv
rtl/rtd_front.sv
rtl/rtd_back.sv
rtl/rtd_result_fifo.sv
rtl/radix_text_decoder.sv
rtl/rtd_checker.sv
dv/radix_text_decoder_checker.sv
dv/radix_text_decoder_tb.sv
